>>> rtl/aocal_pkg.sv
package aocal_pkg;

  localparam int MAX_CALIB_SAMPLES = 4096;
  localparam int LEN_W   = 13;
  localparam int SUM_W   = 29;
  localparam int VAL_W   = 18;
  localparam int MG_W    = 17;
  localparam int FS_W    = 15;
  localparam int DIV_W   = 28;
  localparam int DIVC_W  = $clog2(DIV_W);
  localparam int SHIFT_W = 4;
  localparam int CODE_W  = 3;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_CALIB_LEN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FILT_SHIFT = 2'd1;
  localparam logic [IDX_W-1:0] REG_FULL_SCALE = 2'd2;

  localparam logic [CODE_W-1:0] FS_CODE_4G  = 3'd1;
  localparam logic [CODE_W-1:0] FS_CODE_6G  = 3'd2;
  localparam logic [CODE_W-1:0] FS_CODE_8G  = 3'd3;
  localparam logic [CODE_W-1:0] FS_CODE_16G = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCUM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_FILTER,
    OP_MULT,
    OP_SCALE
  } lane_op_t;

  typedef struct packed {
    lane_op_t               op;
    logic [SHIFT_W-1:0]     shift;
    logic [LEN_W-1:0]       len;
    logic [FS_W-1:0]        fs;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_END,
    ST_MULT,
    ST_SCALE,
    ST_DONE
  } state_t;

  function automatic logic [FS_W-1:0] fs_milli_g(input logic [CODE_W-1:0] code);
    logic [FS_W-1:0] r;
    case (code)
      FS_CODE_4G:  r = 15'd4000;
      FS_CODE_6G:  r = 15'd6000;
      FS_CODE_8G:  r = 15'd8000;
      FS_CODE_16G: r = 15'd16000;
      default:     r = 15'd2000;
    endcase
    return r;
  endfunction

  // 1 g expressed in raw counts for each full scale
  function automatic logic [FS_W-1:0] one_g_counts(input logic [CODE_W-1:0] code);
    logic [FS_W-1:0] r;
    case (code)
      FS_CODE_4G:  r = 15'd8192;
      FS_CODE_6G:  r = 15'd5461;
      FS_CODE_8G:  r = 15'd4096;
      FS_CODE_16G: r = 15'd2048;
      default:     r = 15'd16384;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/aocal_lane.sv
module aocal_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  aocal_pkg::lane_ctl_t                   ctl,
  input  logic signed [15:0]                     sample,
  input  logic [aocal_pkg::FS_W-1:0]             z_adj,
  output logic signed [aocal_pkg::MG_W-1:0]      milli_g
);
  import aocal_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] offset;
  logic signed [VAL_W-1:0] filt;
  logic                    neg;
  logic [DIV_W-1:0]        quot;
  logic [LEN_W-1:0]        rem;
  logic signed [33:0]      prod;

  logic signed [SUM_W-1:0] sample_ext;
  logic [SUM_W-1:0]        mag;
  logic [LEN_W:0]          shifted;
  logic [LEN_W:0]          diff;
  logic signed [VAL_W-1:0] quot_s;
  logic signed [VAL_W-1:0] c;
  logic signed [VAL_W:0]   d;
  logic signed [VAL_W:0]   d_sh;
  logic signed [VAL_W-1:0] filt_next;
  logic signed [33:0]      biased;

  always_comb begin
    sample_ext = {{(SUM_W-16){sample[15]}}, sample};
    mag        = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    shifted    = {rem, quot[DIV_W-1]};
    diff       = shifted - {1'b0, ctl.len};
    quot_s     = neg ? (VAL_W'(0) - quot[VAL_W-1:0]) : quot[VAL_W-1:0];
    c          = {{(VAL_W-16){sample[15]}}, sample} - offset;
    d          = {c[VAL_W-1], c} - {filt[VAL_W-1], filt};
    d_sh       = d >>> ctl.shift;
    filt_next  = filt + d_sh[VAL_W-1:0];
    biased     = prod + (prod[33] ? 34'sd32767 : 34'sd0);
  end

  // model state of the axis
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      offset <= '0;
      filt   <= '0;
    end else begin
      case (ctl.op)
        OP_CLEAR: begin
          sum    <= '0;
          offset <= '0;
          filt   <= '0;
        end
        OP_ACCUM:   sum <= sum + sample_ext;
        OP_DIV_END: begin
          offset <= quot_s - {3'b000, z_adj};
          filt   <= '0;
        end
        OP_FILTER:  filt <= filt_next;
        default: ;
      endcase
    end
  end

  // divider, product and scaled result
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_DIV_LOAD: begin
        neg  <= sum[SUM_W-1];
        quot <= mag[DIV_W-1:0];
        rem  <= '0;
      end
      OP_DIV_STEP: begin
        if (shifted >= {1'b0, ctl.len}) begin
          rem  <= diff[LEN_W-1:0];
          quot <= {quot[DIV_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[LEN_W-1:0];
          quot <= {quot[DIV_W-2:0], 1'b0};
        end
      end
      OP_MULT:  prod <= filt * $signed({1'b0, ctl.fs});
      OP_SCALE: milli_g <= biased[31:15];
      default: ;
    endcase
  end

endmodule

>>> rtl/accel_offset_calib_ema_scaler.sv
// Three-axis accelerometer offset calibration and smoothing. After reset (or a
// word with restart set) the block averages calibration_length raw samples per
// axis, sets each axis offset to the truncated mean (Z also loses 1 g at the
// current full scale) and then, for every later word, subtracts the offsets,
// runs an exponential filter with weight 2^-filter_shift and scales the result
// to milli-g. Each input word yields exactly one result word; data_valid marks
// words that carry filtered values. One word is worked on at a time: a restart
// or an accumulating word passes through the decide and done states, a filtered
// word also through the multiply and scale states, and the word that completes
// calibration through the 28-step bit-serial divider in each axis lane. The
// three axes run in parallel lanes and the output register merges their
// results, so a new word is taken while the previous result still waits
// downstream. Configuration is accepted only between words (cfg_ready is low
// while a word is offered or worked on) and takes effect on the next word.
module accel_offset_calib_ema_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [15:0]                   raw_x,
  input  logic signed [15:0]                   raw_y,
  input  logic signed [15:0]                   raw_z,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 data_valid,
  output logic signed [aocal_pkg::MG_W-1:0]    x_milli_g,
  output logic signed [aocal_pkg::MG_W-1:0]    y_milli_g,
  output logic signed [aocal_pkg::MG_W-1:0]    z_milli_g,
  output logic                                 is_calibrated,
  output logic [aocal_pkg::LEN_W-1:0]          calib_progress,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aocal_pkg::IDX_W-1:0]          cfg_index,
  input  logic [aocal_pkg::LEN_W-1:0]          cfg_data
);
  import aocal_pkg::*;

  state_t state, state_next;

  // configuration registers
  logic [LEN_W-1:0]   calib_len;
  logic [SHIFT_W-1:0] filt_shift;
  logic [CODE_W-1:0]  fs_code;

  // control state
  logic               calibrated;
  logic [LEN_W-1:0]   sample_count;
  logic [DIVC_W-1:0]  div_cnt;
  logic               res_valid;

  // held word
  logic signed [15:0] s_x, s_y, s_z;
  logic               s_restart;

  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   count_inc;
  lane_ctl_t          ctl;
  logic               out_load;
  logic signed [MG_W-1:0] mg_x, mg_y, mg_z;

  // hold off register writes while a word is offered or in the lanes
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign in_stall  = (state != ST_IDLE);
  assign count_inc = sample_count + LEN_W'(1);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // clamp the length into the supported range
  always_comb begin
    if (calib_len == '0)
      len_eff = LEN_W'(1);
    else if (calib_len > LEN_W'(MAX_CALIB_SAMPLES))
      len_eff = LEN_W'(MAX_CALIB_SAMPLES);
    else
      len_eff = calib_len;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (s_restart)
          state_next = ST_DONE;
        else if (!calibrated)
          state_next = (count_inc >= len_eff) ? ST_DIV_LOAD : ST_DONE;
        else
          state_next = ST_MULT;
      end
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      if (div_cnt == DIVC_W'(DIV_W - 1)) state_next = ST_DIV_END;
      ST_DIV_END:  state_next = ST_DONE;
      ST_MULT:     state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_DONE;
      ST_DONE:     if (out_load) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // lane command
  always_comb begin
    ctl.op    = OP_NONE;
    ctl.shift = filt_shift;
    ctl.len   = len_eff;
    ctl.fs    = fs_milli_g(fs_code);
    case (state)
      ST_DECIDE: begin
        if (s_restart)
          ctl.op = OP_CLEAR;
        else if (!calibrated)
          ctl.op = OP_ACCUM;
        else
          ctl.op = OP_FILTER;
      end
      ST_DIV_LOAD: ctl.op = OP_DIV_LOAD;
      ST_DIV:      ctl.op = OP_DIV_STEP;
      ST_DIV_END:  ctl.op = OP_DIV_END;
      ST_MULT:     ctl.op = OP_MULT;
      ST_SCALE:    ctl.op = OP_SCALE;
      default:     ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      calib_len    <= LEN_W'(64);
      filt_shift   <= SHIFT_W'(3);
      fs_code      <= '0;
      calibrated   <= 1'b0;
      sample_count <= '0;
      div_cnt      <= '0;
      res_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CALIB_LEN:  calib_len  <= cfg_data;
          REG_FILT_SHIFT: filt_shift <= cfg_data[SHIFT_W-1:0];
          REG_FULL_SCALE: fs_code    <= cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_DECIDE: begin
          if (s_restart) begin
            calibrated   <= 1'b0;
            sample_count <= '0;
            res_valid    <= 1'b0;
          end else if (!calibrated) begin
            sample_count <= count_inc;
            res_valid    <= 1'b0;
          end else begin
            res_valid    <= 1'b1;
          end
        end
        ST_DIV_LOAD: div_cnt <= '0;
        ST_DIV:      div_cnt <= div_cnt + DIVC_W'(1);
        ST_DIV_END:  calibrated <= 1'b1;
        default: ;
      endcase
      // drop the result once taken, hold it while stalled
      if (out_load)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  // hold the accepted word and the merged result
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_x       <= raw_x;
      s_y       <= raw_y;
      s_z       <= raw_z;
      s_restart <= restart;
    end
    if (out_load) begin
      data_valid     <= res_valid;
      x_milli_g      <= res_valid ? mg_x : '0;
      y_milli_g      <= res_valid ? mg_y : '0;
      z_milli_g      <= res_valid ? mg_z : '0;
      is_calibrated  <= calibrated;
      calib_progress <= sample_count;
    end
  end

  aocal_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (s_x),
    .z_adj   ('0),
    .milli_g (mg_x)
  );

  aocal_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (s_y),
    .z_adj   ('0),
    .milli_g (mg_y)
  );

  aocal_lane u_lane_z (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (s_z),
    .z_adj   (one_g_counts(fs_code)),
    .milli_g (mg_z)
  );

endmodule

>>> tb/ema_scaler_checker.sv
module ema_scaler_checker
  import aocal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [15:0]      raw_x,
  input  logic signed [15:0]      raw_y,
  input  logic signed [15:0]      raw_z,
  input  logic                    restart,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    data_valid,
  input  logic signed [MG_W-1:0]  x_milli_g,
  input  logic signed [MG_W-1:0]  y_milli_g,
  input  logic signed [MG_W-1:0]  z_milli_g,
  input  logic                    is_calibrated,
  input  logic [LEN_W-1:0]        calib_progress,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [LEN_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic                   dv;
    logic signed [MG_W-1:0] x;
    logic signed [MG_W-1:0] y;
    logic signed [MG_W-1:0] z;
    logic                   cal;
    logic [LEN_W-1:0]       prog;
  } mg_word_t;

  mg_word_t mg_expected_q[$];

  logic [LEN_W-1:0]   calib_len;
  logic [SHIFT_W-1:0] filt_shift;
  logic [CODE_W-1:0]  fs_code;

  logic    calibrated;
  int      gathered;
  longint  axis_acc[3];
  int      axis_bias[3];
  int      axis_ema[3];

  function automatic int scale_mg(logic [CODE_W-1:0] code);
    case (code)
      FS_CODE_4G:  return 4000;
      FS_CODE_6G:  return 6000;
      FS_CODE_8G:  return 8000;
      FS_CODE_16G: return 16000;
      default:     return 2000;
    endcase
  endfunction

  function automatic void clear_calibration();
    calibrated = 1'b0;
    gathered   = 0;
    for (int i = 0; i < 3; i++) begin
      axis_acc[i]  = 0;
      axis_bias[i] = 0;
      axis_ema[i]  = 0;
    end
  endfunction

  function automatic mg_word_t smooth_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                                             logic signed [15:0] rz, logic rs);
    int       raw[3];
    int       mg[3];
    int       fs;
    int       len;
    int       diff;
    mg_word_t r;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    mg     = '{0, 0, 0};
    fs     = scale_mg(fs_code);
    r      = '0;
    if (rs) begin
      clear_calibration();
    end else if (!calibrated) begin
      len = calib_len;
      if (len < 1) len = 1;
      if (len > MAX_CALIB_SAMPLES) len = MAX_CALIB_SAMPLES;
      for (int i = 0; i < 3; i++) axis_acc[i] += raw[i];
      gathered++;
      if (gathered >= len) begin
        for (int i = 0; i < 3; i++) begin
          axis_bias[i] = int'(axis_acc[i] / longint'(len));
          axis_ema[i]  = 0;
        end
        axis_bias[2] -= 32768000 / fs;
        calibrated = 1'b1;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        diff = raw[i] - axis_bias[i];
        axis_ema[i] += (diff - axis_ema[i]) >>> filt_shift;
        mg[i] = int'((longint'(axis_ema[i]) * fs) / 32768);
      end
      r.dv = 1'b1;
    end
    r.x    = mg[0][MG_W-1:0];
    r.y    = mg[1][MG_W-1:0];
    r.z    = mg[2][MG_W-1:0];
    r.cal  = calibrated;
    r.prog = gathered[LEN_W-1:0];
    return r;
  endfunction

  assign pending = mg_expected_q.size();

  always @(posedge clk) begin
    mg_word_t want;
    mg_word_t got;
    if (rst) begin
      calib_len  <= 13'd64;
      filt_shift <= 4'd3;
      fs_code    <= '0;
      clear_calibration();
      mg_expected_q.delete();
      fail_count <= 0;
    end else begin
      // mirror register writes; they land before the next word is predicted
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CALIB_LEN:  calib_len  <= cfg_data;
          REG_FILT_SHIFT: filt_shift <= cfg_data[SHIFT_W-1:0];
          REG_FULL_SCALE: fs_code    <= cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        mg_expected_q.push_back(smooth_sample(raw_x, raw_y, raw_z, restart));
      if (out_valid && !out_stall) begin
        got = '{data_valid, x_milli_g, y_milli_g, z_milli_g, is_calibrated, calib_progress};
        if (mg_expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: dv=%0d x=%0d y=%0d z=%0d cal=%0d prog=%0d",
                     got.dv, got.x, got.y, got.z, got.cal, got.prog);
          fail_count <= fail_count + 1;
        end else begin
          want = mg_expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: want dv=%0d x=%0d y=%0d z=%0d cal=%0d prog=%0d | got dv=%0d x=%0d y=%0d z=%0d cal=%0d prog=%0d",
                       want.dv, want.x, want.y, want.z, want.cal, want.prog,
                       got.dv, got.x, got.y, got.z, got.cal, got.prog);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_accel_offset_calib_ema_scaler.sv
module tb_accel_offset_calib_ema_scaler;
  import aocal_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [15:0]     raw_x;
  logic signed [15:0]     raw_y;
  logic signed [15:0]     raw_z;
  logic                   restart;
  logic                   out_valid;
  logic                   out_stall;
  logic                   data_valid;
  logic signed [MG_W-1:0] x_milli_g;
  logic signed [MG_W-1:0] y_milli_g;
  logic signed [MG_W-1:0] z_milli_g;
  logic                   is_calibrated;
  logic [LEN_W-1:0]       calib_progress;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index;
  logic [LEN_W-1:0]       cfg_data;

  int fail_count;
  int pending;
  int words_sent;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int hold_left;
  bit held;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;   // longest word is the one that ends calibration

  accel_offset_calib_ema_scaler i_dut (.*);

  ema_scaler_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall at the phase rate, plus one long hold-off once a few
  // hundred words have gone in, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      held      <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && words_sent >= 300) begin
      held      <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_accel_offset_calib_ema_scaler failed");
      $finish;
    end
  end

  // Offer one sample word, idling first at the phase rate; return once taken.
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic rs);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_x    <= x;
    raw_y    <= y;
    raw_z    <= z;
    restart  <= rs;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  // Drain every outstanding result, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // Mostly random full-range samples, with extremes and occasional restarts.
  task automatic send_random();
    logic signed [15:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(9))
        0:       v[i] = 16'sh8000;
        1:       v[i] = 16'sh7fff;
        2, 3:    v[i] = 16'($urandom_range(400) - 200);
        default: v[i] = 16'($urandom);
      endcase
    end
    send_sample(v[0], v[1], v[2], $urandom_range(99) < 3);
  endtask

  task automatic run_phase(int len, int shift, int code, int count, int lowered);
    wait_idle();
    write_reg(REG_CALIB_LEN, LEN_W'(len));
    write_reg(REG_FILT_SHIFT, LEN_W'(shift));
    write_reg(REG_FULL_SCALE, LEN_W'(code));
    send_sample(0, 0, 0, 1'b1);
    for (int n = 0; n < count; n++) begin
      // drop the length mid-calibration so the next sample finishes it
      if (lowered >= 0 && n == 20) begin
        wait_idle();
        write_reg(REG_CALIB_LEN, LEN_W'(lowered));
      end
      // swap the full scale live once calibrated
      if (n == count / 2) begin
        wait_idle();
        write_reg(REG_FULL_SCALE, LEN_W'($urandom_range(7)));
      end
      send_random();
    end
  endtask

  int ph_len[8]   = '{1, 8191, 4, 0, 16, 4096, 3, 2};
  int ph_shift[8] = '{0, 15, 3, 7, 1, 15, 0, 5};
  int ph_code[8]  = '{0, 4, 1, 2, 3, 5, 6, 7};
  int ph_lower[8] = '{-1, 2, -1, -1, -1, 1, -1, -1};

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    raw_x      = '0;
    raw_y      = '0;
    raw_z      = '0;
    restart    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    words_sent = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short calibration on the rails, then extreme samples
    write_reg(REG_CALIB_LEN, 2);
    write_reg(REG_FILT_SHIFT, 0);
    write_reg(REG_FULL_SCALE, 0);
    send_sample(0, 0, 0, 1'b1);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 0, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(0, 0, 0, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    send_sample(-1, -1, -1, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_sample(1, -1, 16'sh4000, 1'b0);

    // random phases, cycling the idling pattern
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      run_phase(ph_len[p], ph_shift[p], ph_code[p], 135, ph_lower[p]);
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_accel_offset_calib_ema_scaler passed");
    else
      $display("tb_accel_offset_calib_ema_scaler failed");
    $finish;
  end

endmodule
